// File: hw/rtl/kdcp_pkg.sv
// Shared types, character codes and fixed-point constants for the keyed decimal
// command parser. Used by every module of the block; depends on nothing else.
package kdcp_pkg;

    localparam int MAX_FRAME       = 64;
    localparam int FRACTION_DIGITS = 7;

    localparam int BYTE_W      = 8;
    localparam int TARGET_W    = 4;
    localparam int VALUE_W     = 32;
    localparam int INT_W       = 16;
    localparam int FRAC_W      = 24;
    localparam int FCOUNT_W    = 4;
    localparam int FRAME_POS_W = $clog2(MAX_FRAME + 1);

    localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_BANG   = 8'h21;
    localparam logic [BYTE_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_POINT  = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE    = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_THREE  = 8'h33;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_P      = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_I      = 8'h49;
    localparam logic [BYTE_W-1:0] CHAR_D      = 8'h44;

    localparam logic [INT_W-1:0]  INT_LIMIT  = 16'd32767;
    localparam logic [FRAC_W-1:0] FRAC_LIMIT = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_EQUALS = 2'd1,
        STATUS_BAD_CHAR  = 2'd2,
        STATUS_TOO_LONG  = 2'd3
    } status_t;

    // Power of ten, used for elaboration-time constants and a small weight table.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    localparam logic [63:0] FRAC_SCALE = pow10(FRACTION_DIGITS);
    localparam int WEIGHT_W = $clog2(pow10(FRACTION_DIGITS - 1) + 64'd1);
    localparam int FSUM_W   = ((WEIGHT_W + 4 > FRAC_W) ? WEIGHT_W + 4 : FRAC_W) + 1;

    // Rounded conversion: frac = floor((acc * 2^17 + scale) / (2 * scale)).
    // The estimate uses a reciprocal scaled by 2^48 and is at most one low.
    localparam logic [63:0] FRAC_RECIP = (64'd1 << 48) / FRAC_SCALE;
    localparam int RECIP_W = $clog2(FRAC_RECIP + 64'd1);
    localparam logic [63:0] Q_MAX = ((64'hFF_FFFF << 17) + FRAC_SCALE) / (FRAC_SCALE * 2);
    localparam int Q_W      = $clog2(Q_MAX + 64'd1);
    localparam int N_W      = FRAC_W + 17;
    localparam int PROD_W   = (FRAC_W + RECIP_W + 1 > 32 + Q_W) ?
                              FRAC_W + RECIP_W + 1 : 32 + Q_W;
    localparam int MAG_W    = ((Q_W > 31) ? Q_W : 31) + 1;

    // Weight of a fraction digit at a given place after the point.
    function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FCOUNT_W-1:0] count);
        logic [63:0] w;
        w = 64'd0;
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (count == FCOUNT_W'(i)) begin
                w = pow10(FRACTION_DIGITS - 1 - i);
            end
        end
        return WEIGHT_W'(w);
    endfunction

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        status_t             status;
        logic                negative;
        logic [INT_W-1:0]    integer_accum;
        logic [FRAC_W-1:0]   fraction_accum;
    } frame_result_t;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        status_t             status;
        logic                negative;
        logic [INT_W-1:0]    integer_accum;
        logic [FRAC_W-1:0]   fraction_accum;
        logic [Q_W-1:0]      frac_estimate;
    } scaled_result_t;

endpackage

// File: hw/rtl/kdcp_frame_parser.sv
// Frame state and per-byte parsing of the keyed decimal command parser.
// Depends on kdcp_pkg; hands a frame summary to the scaling stage on '!'.
module kdcp_frame_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    input  logic [kdcp_pkg::BYTE_W-1:0] rx_byte,
    output logic                       rx_stall,
    input  logic                       frame_take,
    output logic                       frame_valid,
    output kdcp_pkg::frame_result_t    frame_data
);

    logic [kdcp_pkg::FRAME_POS_W-1:0] pos_reg, pos_next;
    logic [kdcp_pkg::BYTE_W-1:0]      key_first_reg, key_first_next;
    logic [kdcp_pkg::BYTE_W-1:0]      key_second_reg, key_second_next;
    logic                             seen_equals_reg, seen_equals_next;
    logic                             at_start_reg, at_start_next;
    logic                             negative_reg, negative_next;
    logic                             seen_point_reg, seen_point_next;
    logic [kdcp_pkg::FCOUNT_W-1:0]    fcount_reg, fcount_next;
    logic [kdcp_pkg::INT_W-1:0]       int_reg, int_next;
    logic [kdcp_pkg::FRAC_W-1:0]      frac_reg, frac_next;
    logic                             bad_reg, bad_next;
    logic                             frame_valid_reg, frame_valid_next;
    kdcp_pkg::frame_result_t          frame_data_reg, result_now;

    logic                             accept;
    logic                             is_bang;
    logic                             is_digit;
    logic [3:0]                       digit;
    logic [kdcp_pkg::BYTE_W-1:0]      digit_byte;
    logic [18:0]                      int_sum;
    logic [kdcp_pkg::FSUM_W-1:0]      frac_sum;
    logic [3:0]                       row;
    logic                             key_ok;
    logic [kdcp_pkg::BYTE_W-1:0]      key_digit;

    assign rx_stall = frame_valid_reg & ~frame_take;
    assign accept   = rx_valid & ~rx_stall;
    assign is_bang  = (rx_byte == kdcp_pkg::CHAR_BANG);
    assign is_digit = (rx_byte >= kdcp_pkg::CHAR_ZERO) && (rx_byte <= kdcp_pkg::CHAR_NINE);

    assign digit_byte = rx_byte - kdcp_pkg::CHAR_ZERO;
    assign digit      = digit_byte[3:0];
    assign int_sum    = {3'b000, int_reg} * 19'd10 + 19'(digit);
    assign frac_sum   = kdcp_pkg::FSUM_W'(frac_reg)
                      + kdcp_pkg::FSUM_W'(digit) * kdcp_pkg::FSUM_W'(kdcp_pkg::frac_weight(fcount_reg));

    // Target code from the two key bytes.
    assign key_digit = key_second_reg - kdcp_pkg::CHAR_ZERO;
    always_comb
    begin
        row    = 4'd0;
        key_ok = 1'b1;
        priority if (key_first_reg == kdcp_pkg::CHAR_P)
        begin
            row = 4'd0;
        end
        else if (key_first_reg == kdcp_pkg::CHAR_I)
        begin
            row = 4'd3;
        end
        else if (key_first_reg == kdcp_pkg::CHAR_D)
        begin
            row = 4'd6;
        end
        else
        begin
            key_ok = 1'b0;
        end
        if ((key_second_reg < kdcp_pkg::CHAR_ONE) || (key_second_reg > kdcp_pkg::CHAR_THREE))
        begin
            key_ok = 1'b0;
        end
    end

    always_comb
    begin
        result_now.target         = key_ok ? (row + key_digit[3:0]) : 4'd0;
        result_now.negative       = negative_reg;
        result_now.integer_accum  = int_reg;
        result_now.fraction_accum = frac_reg;
        priority if (pos_reg >= kdcp_pkg::FRAME_POS_W'(kdcp_pkg::MAX_FRAME))
        begin
            result_now.status = kdcp_pkg::STATUS_TOO_LONG;
        end
        else if (!seen_equals_reg)
        begin
            result_now.status = kdcp_pkg::STATUS_NO_EQUALS;
        end
        else if (bad_reg)
        begin
            result_now.status = kdcp_pkg::STATUS_BAD_CHAR;
        end
        else
        begin
            result_now.status = kdcp_pkg::STATUS_OK;
        end
    end

    always_comb
    begin
        pos_next         = pos_reg;
        key_first_next   = key_first_reg;
        key_second_next  = key_second_reg;
        seen_equals_next = seen_equals_reg;
        at_start_next    = at_start_reg;
        negative_next    = negative_reg;
        seen_point_next  = seen_point_reg;
        fcount_next      = fcount_reg;
        int_next         = int_reg;
        frac_next        = frac_reg;
        bad_next         = bad_reg;
        frame_valid_next = frame_valid_reg & ~frame_take;

        if (accept)
        begin
            if (is_bang)
            begin
                frame_valid_next = 1'b1;
                pos_next         = '0;
                key_first_next   = '0;
                key_second_next  = '0;
                seen_equals_next = 1'b0;
                at_start_next    = 1'b0;
                negative_next    = 1'b0;
                seen_point_next  = 1'b0;
                fcount_next      = '0;
                int_next         = '0;
                frac_next        = '0;
                bad_next         = 1'b0;
            end
            else if (pos_reg < kdcp_pkg::FRAME_POS_W'(kdcp_pkg::MAX_FRAME))
            begin
                if (pos_reg == kdcp_pkg::FRAME_POS_W'(0))
                begin
                    key_first_next = rx_byte;
                end
                else if (pos_reg == kdcp_pkg::FRAME_POS_W'(1))
                begin
                    key_second_next = rx_byte;
                end
                pos_next = pos_reg + kdcp_pkg::FRAME_POS_W'(1);

                if (rx_byte == kdcp_pkg::CHAR_EQUALS)
                begin
                    seen_equals_next = 1'b1;
                    at_start_next    = 1'b1;
                    negative_next    = 1'b0;
                    seen_point_next  = 1'b0;
                    fcount_next      = '0;
                    int_next         = '0;
                    frac_next        = '0;
                    bad_next         = 1'b0;
                end
                else if (seen_equals_reg)
                begin
                    at_start_next = 1'b0;
                    priority if (at_start_reg && (rx_byte == kdcp_pkg::CHAR_MINUS))
                    begin
                        negative_next = 1'b1;
                    end
                    else if (rx_byte == kdcp_pkg::CHAR_POINT)
                    begin
                        seen_point_next = 1'b1;
                        fcount_next     = '0;
                    end
                    else if (!is_digit)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (!seen_point_reg)
                    begin
                        int_next = (int_sum > 19'(kdcp_pkg::INT_LIMIT)) ?
                                   kdcp_pkg::INT_LIMIT : int_sum[kdcp_pkg::INT_W-1:0];
                    end
                    else if (fcount_reg < kdcp_pkg::FCOUNT_W'(kdcp_pkg::FRACTION_DIGITS))
                    begin
                        frac_next   = (frac_sum > kdcp_pkg::FSUM_W'(kdcp_pkg::FRAC_LIMIT)) ?
                                      kdcp_pkg::FRAC_LIMIT : frac_sum[kdcp_pkg::FRAC_W-1:0];
                        fcount_next = fcount_reg + kdcp_pkg::FCOUNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            key_first_reg   <= '0;
            key_second_reg  <= '0;
            seen_equals_reg <= 1'b0;
            at_start_reg    <= 1'b0;
            negative_reg    <= 1'b0;
            seen_point_reg  <= 1'b0;
            fcount_reg      <= '0;
            int_reg         <= '0;
            frac_reg        <= '0;
            bad_reg         <= 1'b0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            key_first_reg   <= key_first_next;
            key_second_reg  <= key_second_next;
            seen_equals_reg <= seen_equals_next;
            at_start_reg    <= at_start_next;
            negative_reg    <= negative_next;
            seen_point_reg  <= seen_point_next;
            fcount_reg      <= fcount_next;
            int_reg         <= int_next;
            frac_reg        <= frac_next;
            bad_reg         <= bad_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_bang)
        begin
            frame_data_reg <= result_now;
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame_data  = frame_data_reg;

endmodule

// File: hw/rtl/kdcp_frac_scale.sv
// Reciprocal-multiply estimate of the 16-bit rounded fraction.
// Depends on kdcp_pkg; sits between the frame parser and the result stage.
module kdcp_frac_scale
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       frame_valid,
    input  kdcp_pkg::frame_result_t    frame_data,
    output logic                       frame_take,
    input  logic                       scaled_take,
    output logic                       scaled_valid,
    output kdcp_pkg::scaled_result_t   scaled_data
);

    logic                              scaled_valid_reg, scaled_valid_next;
    kdcp_pkg::scaled_result_t          scaled_data_reg;
    logic [kdcp_pkg::PROD_W-1:0]       product;

    assign frame_take = ~scaled_valid_reg | scaled_take;

    // Estimate is exact or one low; the result stage corrects it.
    assign product = kdcp_pkg::PROD_W'(frame_data.fraction_accum)
                   * kdcp_pkg::PROD_W'(kdcp_pkg::FRAC_RECIP)
                   + kdcp_pkg::PROD_W'(64'd1 << 31);

    assign scaled_valid_next = frame_take ? frame_valid : scaled_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scaled_valid_reg <= 1'b0;
        end
        else
        begin
            scaled_valid_reg <= scaled_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_take && frame_valid)
        begin
            scaled_data_reg.target         <= frame_data.target;
            scaled_data_reg.status         <= frame_data.status;
            scaled_data_reg.negative       <= frame_data.negative;
            scaled_data_reg.integer_accum  <= frame_data.integer_accum;
            scaled_data_reg.fraction_accum <= frame_data.fraction_accum;
            scaled_data_reg.frac_estimate  <= product[32 +: kdcp_pkg::Q_W];
        end
    end

    assign scaled_valid = scaled_valid_reg;
    assign scaled_data  = scaled_data_reg;

endmodule

// File: hw/rtl/kdcp_result_stage.sv
// Rounding correction, magnitude saturation, sign and the output register.
// Depends on kdcp_pkg; drives the result channel of the top level.
module kdcp_result_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            scaled_valid,
    input  kdcp_pkg::scaled_result_t        scaled_data,
    output logic                            scaled_take,
    input  logic                            result_stall,
    output logic                            result_valid,
    output logic [kdcp_pkg::TARGET_W-1:0]   target_select,
    output logic signed [kdcp_pkg::VALUE_W-1:0] value_q16,
    output logic [1:0]                      status
);

    logic                              result_valid_reg, result_valid_next;
    logic [kdcp_pkg::TARGET_W-1:0]     target_reg;
    logic [kdcp_pkg::VALUE_W-1:0]      value_reg, value_now;
    kdcp_pkg::status_t                 status_reg;

    logic [kdcp_pkg::N_W-1:0]          numer;
    logic [kdcp_pkg::N_W-1:0]          partial;
    logic [kdcp_pkg::N_W-1:0]          remainder;
    logic [kdcp_pkg::Q_W-1:0]          frac_q;
    logic [kdcp_pkg::MAG_W-1:0]        mag_sum;
    logic [30:0]                       mag;

    assign scaled_take = ~result_valid_reg | ~result_stall;

    assign numer     = (kdcp_pkg::N_W'(scaled_data.fraction_accum) << 17)
                     + kdcp_pkg::N_W'(kdcp_pkg::FRAC_SCALE);
    assign partial   = kdcp_pkg::N_W'(scaled_data.frac_estimate)
                     * kdcp_pkg::N_W'(kdcp_pkg::FRAC_SCALE * 2);
    assign remainder = numer - partial;
    assign frac_q    = scaled_data.frac_estimate
                     + kdcp_pkg::Q_W'(remainder >= kdcp_pkg::N_W'(kdcp_pkg::FRAC_SCALE * 2));

    assign mag_sum = (kdcp_pkg::MAG_W'(scaled_data.integer_accum) << 16)
                   + kdcp_pkg::MAG_W'(frac_q);
    assign mag     = (mag_sum > kdcp_pkg::MAG_W'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : mag_sum[30:0];

    always_comb
    begin
        if (scaled_data.status != kdcp_pkg::STATUS_OK)
        begin
            value_now = '0;
        end
        else if (scaled_data.negative)
        begin
            value_now = 32'd0 - {1'b0, mag};
        end
        else
        begin
            value_now = {1'b0, mag};
        end
    end

    assign result_valid_next = scaled_take ? scaled_valid : result_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scaled_take && scaled_valid)
        begin
            target_reg <= scaled_data.target;
            status_reg <= scaled_data.status;
            value_reg  <= value_now;
        end
    end

    assign result_valid  = result_valid_reg;
    assign target_select = target_reg;
    assign value_q16     = value_reg;
    assign status        = status_reg;

endmodule

// File: hw/rtl/keyed_decimal_command_parser_core.sv
// Keyed decimal command parser: top level with the byte and result channels.
// Depends on kdcp_pkg, kdcp_frame_parser, kdcp_frac_scale and kdcp_result_stage.
// Throughput: one received byte per cycle unless stalled; at most one result per cycle.
// Order: an accepted '!' sets frame_valid, then scaled_valid, then result_valid.
// Reset: rst_n is asynchronous and active low; it clears all frame state and
// empties the result pipeline.
module keyed_decimal_command_parser_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rx_valid,
    input  logic [kdcp_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                 rx_stall,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [kdcp_pkg::TARGET_W-1:0]        target_select,
    output logic signed [kdcp_pkg::VALUE_W-1:0]  value_q16,
    output logic [1:0]                           status
);

    // The design is a short pipeline of three registered parts. The frame
    // parser holds the frame state (position, key bytes, sign, integer and
    // fraction accumulators) and updates it with each accepted byte through a
    // times-ten accumulate and a small weight table multiply. On '!' it
    // latches a frame summary and clears itself, so the next frame's bytes
    // can follow at once unless the stored summary cannot move on.
    //
    // The fraction accumulator counts units of ten to the minus seven. The
    // scaling stage turns it into 16 fraction bits with round half up, using
    // a reciprocal multiply whose estimate is never more than one low. The
    // result stage checks the remainder with a second multiply, fixes the
    // estimate, adds the integer part, saturates the magnitude and applies
    // the sign. A non-zero status forces the value to zero.
    //
    // Each stage moves forward whenever the stage after it is empty or is
    // being emptied, so bubbles collapse. The byte channel stalls only when
    // a finished frame summary cannot move on because all later stages are
    // full and the result channel is stalled; bytes keep flowing while a
    // finished result waits as long as the pipeline has room.

    logic                       frame_valid;
    logic                       frame_take;
    kdcp_pkg::frame_result_t    frame_data;
    logic                       scaled_valid;
    logic                       scaled_take;
    kdcp_pkg::scaled_result_t   scaled_data;

    kdcp_frame_parser u_frame_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_byte     (rx_byte),
        .rx_stall    (rx_stall),
        .frame_take  (frame_take),
        .frame_valid (frame_valid),
        .frame_data  (frame_data)
    );

    kdcp_frac_scale u_frac_scale
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_data   (frame_data),
        .frame_take   (frame_take),
        .scaled_take  (scaled_take),
        .scaled_valid (scaled_valid),
        .scaled_data  (scaled_data)
    );

    kdcp_result_stage u_result_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .scaled_valid  (scaled_valid),
        .scaled_data   (scaled_data),
        .scaled_take   (scaled_take),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .target_select (target_select),
        .value_q16     (value_q16),
        .status        (status)
    );

endmodule

// File: hw/rtl/kdcp_checker.sv
// Port-level assertions for the keyed decimal command parser top level.
// Depends on kdcp_pkg; attached to keyed_decimal_command_parser_core by bind.
module kdcp_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 rx_valid,
    input logic [kdcp_pkg::BYTE_W-1:0]          rx_byte,
    input logic                                 rx_stall,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic [kdcp_pkg::TARGET_W-1:0]        target_select,
    input logic signed [kdcp_pkg::VALUE_W-1:0]  value_q16,
    input logic [1:0]                           status
);

    // A stalled byte transaction holds its valid and its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_stall |=> rx_valid && $stable(rx_byte))
        else $error("stalled byte transaction changed");

    // A stalled result transaction holds its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(target_select)
            && $stable(value_q16) && $stable(status))
        else $error("stalled result transaction changed");

    // Any failed frame reports a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != kdcp_pkg::STATUS_OK) |-> value_q16 == 32'sd0)
        else $error("non-zero value with error status");

    // Target codes stop at D3.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> target_select <= 4'd9)
        else $error("target code out of range");

    // The magnitude saturates before the sign, so the most negative code never shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> value_q16 != 32'sh8000_0000)
        else $error("value reached the most negative code");

endmodule

bind keyed_decimal_command_parser_core kdcp_checker u_kdcp_checker (.*);

// File: bench/keyed_decimal_command_parser_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for keyed_decimal_command_parser_core: streams command frames
// into the byte channel and checks every command against a predictor or a typed row.
// Depends on kdcp_pkg and the parser RTL only.
module keyed_decimal_command_parser_core_tb;
    import kdcp_pkg::*;

    // Run shape. The random part stops after this many accepted bytes.
    localparam int RANDOM_BYTES = 1400;
    localparam int CYCLE_LIMIT  = 200000;
    // Quiet time after the last expected result, to catch any stray extra transaction.
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT     = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_FRAMES     = 23;

    // One parsed command as it leaves the block.
    typedef struct packed {
        logic [TARGET_W-1:0]       target;
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
    } command_t;

    // One directed frame. The loop sends the text, then fill_len copies of fill_char,
    // then the closing '!'. Where typed is set, the command is written out by hand.
    typedef struct {
        string               text;
        logic [BYTE_W-1:0]   fill_char;
        int                  fill_len;
        bit                  typed;
        logic [TARGET_W-1:0] target;
        logic [VALUE_W-1:0]  value;
        status_t             status;
    } frame_row_t;

    frame_row_t directed_frames [N_FRAMES] = '{
        // A lone '!' straight after reset: no key, no '='.
        '{"",                 8'h00, 0,  1'b1, 4'd0, 32'h0000_0000, STATUS_NO_EQUALS},
        // Short frames: a missing key byte reads as zero.
        '{"P",                8'h00, 0,  1'b1, 4'd0, 32'h0000_0000, STATUS_NO_EQUALS},
        '{"P3",               8'h00, 0,  1'b1, 4'd3, 32'h0000_0000, STATUS_NO_EQUALS},
        // Largest positive value: the rounded fraction carries and the magnitude clips.
        '{"P1=32767.9999999", 8'h00, 0,  1'b1, 4'd1, 32'h7FFF_FFFF, STATUS_OK},
        // Integer part saturates at 32767, then the sign is applied.
        '{"D3=-99999",        8'h00, 0,  1'b1, 4'd9, 32'h8001_0000, STATUS_OK},
        '{"I2=1x",            8'h00, 0,  1'b1, 4'd5, 32'h0000_0000, STATUS_BAD_CHAR},
        // A minus sign that is not the first value byte is a bad character.
        '{"P1=1-2",           8'h00, 0,  1'b1, 4'd1, 32'h0000_0000, STATUS_BAD_CHAR},
        // Empty values, with and without the sign.
        '{"D2=",              8'h00, 0,  1'b1, 4'd8, 32'h0000_0000, STATUS_OK},
        '{"D2=-",             8'h00, 0,  1'b1, 4'd8, 32'h0000_0000, STATUS_OK},
        // Over-long frames; too long wins over a missing '='.
        '{"D1=",              "7",   70, 1'b1, 4'd7, 32'h0000_0000, STATUS_TOO_LONG},
        '{"P1",               "x",   70, 1'b1, 4'd1, 32'h0000_0000, STATUS_TOO_LONG},
        // Without '=' nothing is parsed, so junk cannot raise a bad character.
        '{"P1abc",            8'h00, 0,  1'b1, 4'd1, 32'h0000_0000, STATUS_NO_EQUALS},
        // Both extremes of the byte range inside a value.
        '{"P1=",              8'h00, 1,  1'b1, 4'd1, 32'h0000_0000, STATUS_BAD_CHAR},
        '{"I1=\377",          8'h00, 0,  1'b1, 4'd4, 32'h0000_0000, STATUS_BAD_CHAR},
        // The rest are left to the predictor.
        '{"P2=-12.5",         8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"I1=0.5.25",        8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"I3=0.123456789",   8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"P1=0.0000153",     8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"I3=-0.0000076",    8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"P2=x=5",           8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"X1=3",             8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"P4=2.75",          8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK},
        '{"D1=9.9.9",         8'h00, 0,  1'b0, 4'd0, 32'h0000_0000, STATUS_OK}
    };

    // Every input of the block starts at a known value.
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       rx_valid     = 1'b0;
    logic [BYTE_W-1:0]          rx_byte      = '0;
    logic                       rx_stall;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [TARGET_W-1:0]        target_select;
    logic signed [VALUE_W-1:0]  value_q16;
    logic [1:0]                 status;

    // Stimulus controls shared between the byte sender and the result receiver.
    logic quiet    = 1'b0;  // neither side idles while this is high
    logic hold_req = 1'b0;  // asks the receiver for its one long hold-off
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    command_t pending_commands[$];
    int       bytes_accepted = 0;
    int       mismatches     = 0;
    int       cycle_count    = 0;

    // Predictor state for the frame being gathered.
    logic [FRAME_POS_W-1:0] frame_len   = '0;
    logic [BYTE_W-1:0]      key_letter  = '0;
    logic [BYTE_W-1:0]      key_digit   = '0;
    logic                   have_equals = 1'b0;
    logic                   value_start = 1'b0;
    logic                   minus       = 1'b0;
    logic                   have_point  = 1'b0;
    logic                   saw_junk    = 1'b0;
    logic [FCOUNT_W-1:0]    frac_places = '0;
    logic [INT_W-1:0]       whole_part  = '0;
    logic [FRAC_W-1:0]      frac_part   = '0;

    keyed_decimal_command_parser_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx_valid      (rx_valid),
        .rx_byte       (rx_byte),
        .rx_stall      (rx_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .target_select (target_select),
        .value_q16     (value_q16),
        .status        (status)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Forget everything about the number after the last '='.
    function automatic void clear_number();
        value_start = 1'b0;
        minus       = 1'b0;
        have_point  = 1'b0;
        saw_junk    = 1'b0;
        frac_places = '0;
        whole_part  = '0;
        frac_part   = '0;
    endfunction

    // Advances the predicted parser by one accepted byte. On '!' it hands back the
    // command that the block must produce and starts a fresh frame.
    function automatic void parse_command_byte(input logic [BYTE_W-1:0] b, output bit done,
                                               output command_t cmd);
        logic            first;
        logic [3:0]      digit;
        logic [31:0]     whole_next;
        longint unsigned weight;
        longint unsigned frac_next;
        longint unsigned scale;
        longint unsigned frac16;
        longint unsigned mag;
        done = 1'b0;
        cmd  = '0;
        if (b == CHAR_BANG)
        begin
            done = 1'b1;
            // Rows of three targets: P first, then I, then D.
            if (key_digit >= CHAR_ONE && key_digit <= CHAR_THREE)
            begin
                if (key_letter == CHAR_P)
                    cmd.target = 4'(key_digit - CHAR_ZERO);
                else if (key_letter == CHAR_I)
                    cmd.target = 4'(key_digit - CHAR_ZERO + 3);
                else if (key_letter == CHAR_D)
                    cmd.target = 4'(key_digit - CHAR_ZERO + 6);
            end
            if (frame_len >= MAX_FRAME)
                cmd.status = STATUS_TOO_LONG;
            else if (!have_equals)
                cmd.status = STATUS_NO_EQUALS;
            else if (saw_junk)
                cmd.status = STATUS_BAD_CHAR;
            else
            begin
                cmd.status = STATUS_OK;
                // Decimal fraction to 16 bits, rounding half up.
                scale = 1;
                repeat (FRACTION_DIGITS) scale = scale * 10;
                frac16 = (longint'(frac_part) * 65536 + scale / 2) / scale;
                mag = (longint'(whole_part) << 16) + frac16;
                if (mag > 64'h7FFF_FFFF)
                    mag = 64'h7FFF_FFFF;
                cmd.value = minus ? -mag[31:0] : mag[31:0];
            end
            frame_len   = '0;
            key_letter  = '0;
            key_digit   = '0;
            have_equals = 1'b0;
            clear_number();
            return;
        end

        // Past the frame limit every byte but '!' is dropped.
        if (frame_len >= MAX_FRAME)
            return;
        if (frame_len == 0)
            key_letter = b;
        else if (frame_len == 1)
            key_digit = b;
        frame_len = frame_len + 1'b1;

        if (b == CHAR_EQUALS)
        begin
            have_equals = 1'b1;
            clear_number();
            value_start = 1'b1;
        end
        else if (have_equals)
        begin
            first       = value_start;
            value_start = 1'b0;
            if (first && b == CHAR_MINUS)
                minus = 1'b1;
            else if (b == CHAR_POINT)
            begin
                // Each point restarts the digit weights at one tenth.
                have_point  = 1'b1;
                frac_places = '0;
            end
            else if (b < CHAR_ZERO || b > CHAR_NINE)
                saw_junk = 1'b1;
            else
            begin
                digit = 4'(b - CHAR_ZERO);
                if (!have_point)
                begin
                    whole_next = 32'(whole_part) * 32'd10 + 32'(digit);
                    whole_part = (whole_next > 32'(INT_LIMIT)) ? INT_LIMIT
                                                               : whole_next[INT_W-1:0];
                end
                else if (frac_places < FRACTION_DIGITS)
                begin
                    weight = 1;
                    repeat (FRACTION_DIGITS - 1 - int'(frac_places)) weight = weight * 10;
                    frac_next = longint'(frac_part) + longint'(digit) * weight;
                    frac_part = (frac_next > longint'(FRAC_LIMIT)) ? FRAC_LIMIT
                                                                   : frac_next[FRAC_W-1:0];
                    frac_places = frac_places + 1'b1;
                end
            end
        end
    endfunction

    // Offers one byte and waits for its transaction. Random idle cycles go in front.
    // Valid stays high after acceptance so back-to-back bytes need no re-raise; the
    // predictor runs on the accepted byte, and a pinned command replaces its result.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit pinned = 1'b0,
                             input command_t pinned_cmd = '0);
        bit       done;
        command_t cmd;
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        bytes_accepted++;
        parse_command_byte(b, done, cmd);
        if (done)
            pending_commands.push_back(pinned ? pinned_cmd : cmd);
    endtask

    // Byte sender: reset, the directed frames, then random frames.
    initial
    begin
        int                random_start;
        int                kind;
        int                pick;
        int                frame_idx;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] frame_bytes[$];
        command_t          pin;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_frames[r])
        begin
            for (int k = 0; k < directed_frames[r].text.len(); k++)
                send_byte(directed_frames[r].text[k]);
            repeat (directed_frames[r].fill_len)
                send_byte(directed_frames[r].fill_char);
            pin.target = directed_frames[r].target;
            pin.value  = directed_frames[r].value;
            pin.status = directed_frames[r].status;
            send_byte(CHAR_BANG, directed_frames[r].typed, pin);
        end

        // Mostly well-formed commands with random keys and numbers, salted with line
        // noise, runt frames, over-long frames, missing or repeated '=', stray bytes,
        // repeated points and long digit strings that push both parts into saturation.
        random_start = bytes_accepted;
        while (bytes_accepted - random_start < RANDOM_BYTES)
        begin
            frame_idx = bytes_accepted - random_start;
            // A stretch with no idling on either side, and one long receiver hold-off
            // early on while the sender keeps offering bytes.
            quiet    <= (frame_idx >= 900 && frame_idx < 1200);
            hold_req <= (frame_idx >= 300);
            frame_bytes.delete();
            kind = $urandom_range(99);
            if (kind < 6)
            begin
                repeat ($urandom_range(10))
                    frame_bytes.push_back(8'($urandom_range(255)));
                frame_bytes.push_back(CHAR_BANG);
            end
            else
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                    frame_bytes.push_back(8'($urandom_range(255)));
                else if (pick < 4)
                    frame_bytes.push_back(CHAR_P);
                else if (pick < 7)
                    frame_bytes.push_back(CHAR_I);
                else
                    frame_bytes.push_back(CHAR_D);
                if ($urandom_range(9) == 0)
                    frame_bytes.push_back(8'($urandom_range(255)));
                else
                    frame_bytes.push_back(8'(CHAR_ONE + $urandom_range(2)));

                if (kind < 10)
                begin
                    repeat (MAX_FRAME + $urandom_range(10))
                    begin
                        do
                            b = 8'($urandom_range(255));
                        while (b == CHAR_BANG);
                        frame_bytes.push_back(b);
                    end
                end
                else
                begin
                    if ($urandom_range(19) != 0)
                        frame_bytes.push_back(CHAR_EQUALS);
                    if ($urandom_range(9) == 0)
                    begin
                        // Junk that a second '=' must wipe out.
                        frame_bytes.push_back(8'($urandom_range(8'h7E, 8'h41)));
                        frame_bytes.push_back(CHAR_EQUALS);
                    end
                    if ($urandom_range(9) < 4)
                        frame_bytes.push_back(CHAR_MINUS);
                    repeat ($urandom_range(6))
                        frame_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
                    if ($urandom_range(9) < 6)
                    begin
                        frame_bytes.push_back(CHAR_POINT);
                        repeat ($urandom_range(9))
                            frame_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
                        if ($urandom_range(9) == 0)
                        begin
                            frame_bytes.push_back(CHAR_POINT);
                            repeat ($urandom_range(8))
                                frame_bytes.push_back(8'(CHAR_ZERO + $urandom_range(9)));
                        end
                    end
                    if ($urandom_range(99) < 8)
                        frame_bytes.insert($urandom_range(frame_bytes.size(), 2),
                                           8'($urandom_range(255)));
                end
                frame_bytes.push_back(CHAR_BANG);
            end
            foreach (frame_bytes[i])
                send_byte(frame_bytes[i]);
        end
        rx_valid <= 1'b0;

        // Let every expected command arrive, then watch a little longer for extras.
        while (pending_commands.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Result receiver: random stalls, one long hold-off on request, none while quiet.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    // Every result transaction is matched against the oldest pending command.
    always @(posedge clk)
    begin : check_commands
        command_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_commands.size() == 0)
            begin
                $error("unexpected result: target_select %0d value_q16 %0d status %0d",
                       target_select, value_q16, status);
                mismatches++;
            end
            else
            begin
                want = pending_commands.pop_front();
                if (target_select !== want.target)
                begin
                    $error("target_select: expected %0d, actual %0d", want.target,
                           target_select);
                    mismatches++;
                end
                if (value_q16 !== want.value)
                begin
                    $error("value_q16: expected %0d, actual %0d", want.value, value_q16);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
